FILE: design/xbr_pkg.sv
// ----------------------------------------------------------------------------
// xbr_pkg
// Shared widths, reset values, command codes and the controller/datapath
// interface types for the xoshiro256++ bounded random block.
// ----------------------------------------------------------------------------
package xbr_pkg;

    localparam int WORD_W   = 64;
    localparam int N_SEEDS  = 4;
    localparam int IDX_W    = $clog2(N_SEEDS);
    localparam int ADDR_W   = IDX_W + 3;          // 8-byte register stride
    localparam int CMD_W    = 2;
    localparam int DIV_STEPS = WORD_W;            // one quotient bit per cycle
    localparam int CNT_W    = $clog2(DIV_STEPS);

    // xoshiro256++ shift and rotate amounts
    localparam int ROT_RESULT = 23;
    localparam int SHIFT_T    = 17;
    localparam int ROT_STATE  = 45;

    typedef logic [WORD_W-1:0]        word_t;
    typedef word_t [N_SEEDS-1:0]      seed_arr_t;

    // seed registers and generator state come out of reset as 1, 2, 3, 4
    localparam seed_arr_t SEED_RESET = {64'd4, 64'd3, 64'd2, 64'd1};

    typedef enum logic [CMD_W-1:0] {
        CMD_RELOAD  = 2'd0,
        CMD_RAW     = 2'd1,
        CMD_BOUNDED = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_RELOAD,      // state <- seeds, result <- 0
        OP_ZERO,        // result <- 0
        OP_RAW,         // step generator, result <- raw output
        OP_RAW_BAD,     // step generator, result <- raw output, flag bad bound
        OP_DRAW_DIV,    // step generator, start remainder of raw output
        OP_DIV_STEP,    // one restoring-division step
        OP_TAKE_REM     // result <- remainder
    } op_t;

    typedef struct packed {
        op_t  op;
        logic latch_bound;
        logic load_out;
    } xbr_ctl_t;

    typedef struct packed {
        logic bound_zero;   // bound on the input port is zero
        logic reject;       // current draw falls in the biased tail
    } xbr_sts_t;

endpackage

FILE: design/xbr_regs.sv
// ----------------------------------------------------------------------------
// xbr_regs
// APB register file holding the four 64-bit seed words.
// ----------------------------------------------------------------------------
module xbr_regs
    import xbr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0] pwdata,
    output logic [WORD_W-1:0] prdata,
    output logic              pready,
    output seed_arr_t         seeds
);

    seed_arr_t        seed_reg;
    logic [IDX_W-1:0] idx;

    assign idx    = paddr[ADDR_W-1:3];
    assign pready = 1'b1;
    assign prdata = seed_reg[idx];
    assign seeds  = seed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
        end else if (psel && penable && pwrite) begin
            seed_reg[idx] <= pwdata;
        end
    end

endmodule

FILE: design/xbr_datapath.sv
// ----------------------------------------------------------------------------
// xbr_datapath
// Generator state, one-step xoshiro256++ update, bit-serial remainder unit,
// rejection compare and the result/output registers.
// ----------------------------------------------------------------------------
module xbr_datapath
    import xbr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  xbr_ctl_t          ctl,
    output xbr_sts_t          sts,
    input  seed_arr_t         seeds,
    input  logic [WORD_W-1:0] s_bound,
    output logic [WORD_W-1:0] m_value,
    output logic              m_bad_bound
);

    seed_arr_t st_reg;
    word_t     bound_reg, x_reg, xsh_reg, rem_reg;
    word_t     res_value_reg, out_value_reg;
    logic      res_bad_reg, out_bad_reg;

    word_t     sum03, raw, t_val, n0, n1, n2, n3, n3_x;
    seed_arr_t st_next;

    logic [WORD_W:0] trial, trial_diff;
    word_t           rem_step;

    // xoshiro256++ output and state advance
    always_comb begin
        sum03 = st_reg[0] + st_reg[3];
        raw   = ((sum03 << ROT_RESULT) | (sum03 >> (WORD_W - ROT_RESULT))) + st_reg[0];
        t_val = st_reg[1] << SHIFT_T;
        n2    = st_reg[2] ^ st_reg[0];
        n3_x  = st_reg[3] ^ st_reg[1];
        n1    = st_reg[1] ^ n2;
        n0    = st_reg[0] ^ n3_x;
        n3    = (n3_x << ROT_STATE) | (n3_x >> (WORD_W - ROT_STATE));
        st_next = {n3, n2 ^ t_val, n1, n0};
    end

    // restoring division: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial      = {rem_reg, xsh_reg[WORD_W-1]};
        trial_diff = trial - {1'b0, bound_reg};
        rem_step   = trial_diff[WORD_W] ? trial[WORD_W-1:0] : trial_diff[WORD_W-1:0];
    end

    assign sts.bound_zero = (s_bound == '0);
    assign sts.reject     = (x_reg - rem_reg) > (WORD_W'(0) - bound_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= SEED_RESET;
        end else begin
            unique case (ctl.op)
                OP_RELOAD:                      st_reg <= seeds;
                OP_RAW, OP_RAW_BAD, OP_DRAW_DIV: st_reg <= st_next;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.latch_bound) begin
            bound_reg <= s_bound;
        end
        unique case (ctl.op)
            OP_RELOAD, OP_ZERO: begin
                res_value_reg <= '0;
                res_bad_reg   <= 1'b0;
            end
            OP_RAW: begin
                res_value_reg <= raw;
                res_bad_reg   <= 1'b0;
            end
            OP_RAW_BAD: begin
                res_value_reg <= raw;
                res_bad_reg   <= 1'b1;
            end
            OP_DRAW_DIV: begin
                x_reg   <= raw;
                xsh_reg <= raw;
                rem_reg <= '0;
            end
            OP_DIV_STEP: begin
                rem_reg <= rem_step;
                xsh_reg <= xsh_reg << 1;
            end
            OP_TAKE_REM: begin
                res_value_reg <= rem_reg;
                res_bad_reg   <= 1'b0;
            end
            default: ;
        endcase
        if (ctl.load_out) begin
            out_value_reg <= res_value_reg;
            out_bad_reg   <= res_bad_reg;
        end
    end

    assign m_value     = out_value_reg;
    assign m_bad_bound = out_bad_reg;

endmodule

FILE: design/xbr_ctrl.sv
// ----------------------------------------------------------------------------
// xbr_ctrl
// Command sequencer: decodes each item, runs the division and rejection
// loop, and hands results to the output register.
// ----------------------------------------------------------------------------
module xbr_ctrl
    import xbr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [CMD_W-1:0] s_cmd,
    output logic             m_valid,
    input  logic             m_ready,
    output xbr_ctl_t         ctl,
    input  xbr_sts_t         sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             accept, out_free;

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        ctl.op          = OP_NONE;
        ctl.latch_bound = 1'b0;
        ctl.load_out    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ctl.latch_bound = 1'b1;
                    state_next      = ST_FINISH;
                    unique case (cmd_t'(s_cmd))
                        CMD_RELOAD: ctl.op = OP_RELOAD;
                        CMD_RAW:    ctl.op = OP_RAW;
                        CMD_BOUNDED: begin
                            if (sts.bound_zero) begin
                                ctl.op = OP_RAW_BAD;
                            end else begin
                                ctl.op     = OP_DRAW_DIV;
                                cnt_next   = '0;
                                state_next = ST_DIV;
                            end
                        end
                        CMD_UNUSED: ctl.op = OP_ZERO;
                        default:    ctl.op = OP_ZERO;
                    endcase
                end
            end
            ST_DIV: begin
                ctl.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.reject) begin
                    // biased tail: draw again
                    ctl.op     = OP_DRAW_DIV;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    ctl.op     = OP_TAKE_REM;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    ctl.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: design/xoshiro256_plus_bounded_random.sv
// ----------------------------------------------------------------------------
// xoshiro256_plus_bounded_random
// xoshiro256++ generator with reload, raw draw and unbiased bounded draw.
// ----------------------------------------------------------------------------
// Usage:
//   Seeds sit in four 64-bit APB registers at byte addresses 0, 8, 16, 24;
//   write them only while the block is idle. pready is tied high.
//   Each input item (s_cmd, s_bound) gives exactly one result item
//   (m_value, m_bad_bound) on the valid/ready result channel.
//   s_cmd: reload copies the seeds into the generator state and returns 0;
//   raw returns one generator output; bounded returns draw mod s_bound,
//   drawing again while the draw lands in the biased tail. A zero bound
//   returns the raw draw with m_bad_bound set. The unused code returns 0.
//   For reload, raw, unused and zero-bound items the controller steps from
//   IDLE to FINISH, which loads the output register and raises m_valid as
//   soon as that register is free; the next item is taken back in IDLE.
//   A bounded draw runs the bit-serial remainder unit in DIV, then CHECK
//   and FINISH; a rejected draw redoes DIV. One item is handled at a time.
//   The output register holds a finished result, so the next item is
//   accepted while the receiver stalls; that item then waits in the
//   controller until the output register frees up.
//   Reset (aresetn low, synchronous) sets seeds and state to 1, 2, 3, 4
//   and empties the result channel.
// ----------------------------------------------------------------------------
module xoshiro256_plus_bounded_random
    import xbr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0] pwdata,
    output logic [WORD_W-1:0] prdata,
    output logic              pready,
    // command channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CMD_W-1:0]  s_cmd,
    input  logic [WORD_W-1:0] s_bound,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_value,
    output logic              m_bad_bound
);

    seed_arr_t seeds;
    xbr_ctl_t  ctl;
    xbr_sts_t  sts;

    // seed register file
    xbr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .seeds   (seeds)
    );

    // sequencer: decode, divide loop, reject loop, output hand-off
    xbr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl),
        .sts     (sts)
    );

    // generator state, remainder unit and result registers
    xbr_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .sts         (sts),
        .seeds       (seeds),
        .s_bound     (s_bound),
        .m_value     (m_value),
        .m_bad_bound (m_bad_bound)
    );

endmodule

FILE: sim/tb_xoshiro256_plus_bounded_random.sv
// ----------------------------------------------------------------------------
// tb_xoshiro256_plus_bounded_random
// Self-checking bench for the xoshiro256++ bounded random block. It programs
// the seed registers over APB and drives reload, raw, bounded and unused
// commands. A local generator model predicts each result item, and every
// result is compared against the oldest prediction. Directed corners come
// first, then random traffic with random idling on both channels, one long
// result-side hold-off, and a final full-rate stretch.
// ----------------------------------------------------------------------------
module tb_xoshiro256_plus_bounded_random;
    import xbr_pkg::*;

    // cycles without a transfer on either channel before a hang is declared;
    // covers the long hold-off plus a bounded draw with many rejections
    localparam int STALL_LIMIT = 20000;
    // length of the result-side hold-off in the back-pressure test
    localparam int HOLD_CYCLES = 400;
    // cycles to watch for stray results once everything has arrived
    localparam int TAIL_CYCLES = 80;

    typedef struct packed {
        word_t value;
        logic  bad_bound;
    } draw_res_t;

    logic              aclk;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [WORD_W-1:0] pwdata;
    logic [WORD_W-1:0] prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    logic [CMD_W-1:0]  s_cmd;
    logic [WORD_W-1:0] s_bound;
    logic              m_valid;
    logic              m_ready;
    logic [WORD_W-1:0] m_value;
    logic              m_bad_bound;

    // model copy of the seed registers and the generator state
    word_t       seed_regs [N_SEEDS];
    word_t       gen_state [N_SEEDS];
    // predicted result items, oldest first
    draw_res_t   pending_draws [$];
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    // idling controls for the item driver and the result sink
    bit          tx_gaps;
    bit          rx_stalls;
    bit          hold_req;

    xoshiro256_plus_bounded_random dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_bound     (s_bound),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_bad_bound (m_bad_bound)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Generator model
    // ------------------------------------------------------------------------
    function automatic word_t rotl(word_t v, int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // advance the xoshiro256++ state once and return its output word
    function automatic word_t gen_advance();
        word_t out_w;
        word_t t;
        out_w = rotl(gen_state[0] + gen_state[3], ROT_RESULT) + gen_state[0];
        t = gen_state[1] << SHIFT_T;
        gen_state[2] = gen_state[2] ^ gen_state[0];
        gen_state[3] = gen_state[3] ^ gen_state[1];
        gen_state[1] = gen_state[1] ^ gen_state[2];
        gen_state[0] = gen_state[0] ^ gen_state[3];
        gen_state[2] = gen_state[2] ^ t;
        gen_state[3] = rotl(gen_state[3], ROT_STATE);
        return out_w;
    endfunction

    // result item the block must return for one accepted command
    function automatic draw_res_t predict_draw(cmd_t c, word_t bound);
        draw_res_t res;
        word_t     limit;
        word_t     x;
        word_t     r;
        res = '0;
        case (c)
            CMD_RELOAD: begin
                for (int i = 0; i < N_SEEDS; i++) gen_state[i] = seed_regs[i];
            end
            CMD_RAW: begin
                res.value = gen_advance();
            end
            CMD_BOUNDED: begin
                if (bound == '0) begin
                    // undefined bound: hand back the raw draw and flag it
                    res.value     = gen_advance();
                    res.bad_bound = 1'b1;
                end else begin
                    // redraw while the draw lands in the biased tail
                    limit = -bound;
                    x = gen_advance();
                    r = x % bound;
                    while ((x - r) > limit) begin
                        x = gen_advance();
                        r = x % bound;
                    end
                    res.value = r;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------------
    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic cmd_t pick_cmd();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return CMD_RELOAD;
        if (sel == 1) return CMD_UNUSED;
        if (sel < 8) return CMD_RAW;
        return CMD_BOUNDED;
    endfunction

    // spread bounds over zero, all ones, tiny, powers of two, the heavily
    // rejecting upper half, 32-bit and full-width values
    function automatic word_t pick_bound();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        case (sel)
            0:       return '0;
            1:       return '1;
            2, 3:    return word_t'($urandom_range(1, 16));
            4, 5:    return word_t'(1) << $urandom_range(0, WORD_W - 1);
            6, 7:    return rand_word() | {1'b1, {(WORD_W - 1){1'b0}}};
            8, 9:    return word_t'($urandom);
            default: return rand_word();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Offer one item, hold it until accepted, then record its prediction.
    // Keep s_valid high between back-to-back items; drop it only for a gap.
    task automatic send_item(cmd_t c, word_t bound);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= c;
        s_bound <= bound;
        do @(posedge aclk); while (!s_ready);
        pending_draws.push_back(predict_draw(c, bound));
    endtask

    // Drop valid and wait until every predicted item has come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_draws.size() != 0);
    endtask

    // Write all four seed registers back to back; psel stays high between
    // writes so each signal sees one assignment per edge.
    task automatic program_seeds(seed_arr_t seeds);
        for (int i = 0; i < N_SEEDS; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_W'(i * 8);
            pwdata  <= seeds[i];
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            seed_regs[i] = seeds[i];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random stall bursts, plus one long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    function automatic void log_fault(string msg);
        if (mismatches < 10) $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endfunction

    always @(posedge aclk) begin : result_check
        draw_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_draws.size() == 0) begin
                log_fault($sformatf("unexpected item value=%h bad_bound=%b",
                                    m_value, m_bad_bound));
            end else begin
                want = pending_draws.pop_front();
                if (m_value !== want.value)
                    log_fault($sformatf("value expected %h got %h",
                                        want.value, m_value));
                if (m_bad_bound !== want.bad_bound)
                    log_fault($sformatf("bad_bound expected %b got %b",
                                        want.bad_bound, m_bad_bound));
            end
        end
    end

    // Abort when nothing moves on either channel for too long.
    always @(posedge aclk) begin : stall_watch
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Draw straight out of reset, then reload the reset seeds and draw again.
    task automatic test_reset_seeds();
        send_item(CMD_RAW, '0);
        send_item(CMD_RAW, '1);
        send_item(CMD_BOUNDED, 64'd10);
        send_item(CMD_RELOAD, '1);
        send_item(CMD_RAW, '0);
    endtask

    // Hit every command and the bound extremes at least once.
    task automatic test_command_corners();
        send_item(CMD_BOUNDED, 64'd1);
        send_item(CMD_BOUNDED, '0);
        send_item(CMD_BOUNDED, '1);
        send_item(CMD_BOUNDED, 64'h8000_0000_0000_0001);
        send_item(CMD_BOUNDED, 64'h8000_0000_0000_0000);
        send_item(CMD_BOUNDED, 64'd2);
        send_item(CMD_UNUSED, rand_word());
        send_item(CMD_UNUSED, '1);
        send_item(CMD_RAW, '1);
        send_item(CMD_RELOAD, rand_word());
    endtask

    // All-zero seeds lock the generator at zero; bounded draws must not spin.
    task automatic test_zero_state();
        wait_idle();
        program_seeds('0);
        send_item(CMD_RELOAD, '0);
        send_item(CMD_RAW, '0);
        send_item(CMD_BOUNDED, 64'd7);
        send_item(CMD_BOUNDED, '0);
        send_item(CMD_BOUNDED, '1);
        send_item(CMD_UNUSED, '0);
    endtask

    // Reprogram the seeds, reload them, then run random commands.
    task automatic test_random_draws(int unsigned n_items, seed_arr_t seeds);
        wait_idle();
        program_seeds(seeds);
        send_item(CMD_RELOAD, rand_word());
        repeat (n_items) send_item(pick_cmd(), pick_bound());
    endtask

    // Hold the result side off while items keep coming so the block fills
    // its output register and stalls the input.
    task automatic test_output_backpressure();
        bit saved_gaps;
        saved_gaps = tx_gaps;
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        repeat (12) begin
            if ($urandom_range(0, 1) == 0) send_item(CMD_RAW, rand_word());
            else send_item(CMD_BOUNDED, word_t'($urandom_range(1, 100)));
        end
        tx_gaps = saved_gaps;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        seed_arr_t rnd_seeds;
        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_valid   = 1'b0;
        s_cmd     = CMD_RELOAD;
        s_bound   = '0;
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        hold_req  = 1'b0;
        for (int i = 0; i < N_SEEDS; i++) begin
            seed_regs[i] = SEED_RESET[i];
            gen_state[i] = SEED_RESET[i];
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_seeds();
        test_command_corners();
        test_zero_state();

        // random traffic with idling on both sides
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        test_random_draws(150, SEED_RESET);
        for (int i = 0; i < N_SEEDS; i++) rnd_seeds[i] = rand_word();
        test_random_draws(150, rnd_seeds);
        test_random_draws(100, {N_SEEDS{64'hFFFF_FFFF_FFFF_FFFF}});
        test_random_draws(80, {64'h8000_0000_0000_0000, 64'd0,
                               64'hFFFF_FFFF_FFFF_FFFF, 64'd1});
        test_output_backpressure();

        // final stretch at full rate
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        for (int i = 0; i < N_SEEDS; i++) rnd_seeds[i] = rand_word();
        test_random_draws(120, rnd_seeds);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_draws.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
